// ===== hdl/msc_pkg.sv =====
// constants and types for the four-core mesi snoop coherence block
// no dependencies
package msc_pkg;
   localparam int NUM_CORES   = 4;
   localparam int NUM_SETS    = 64;
   localparam int WAYS        = 2;
   localparam int BLOCK_BYTES = 32;
   localparam int CORE_W   = $clog2(NUM_CORES);
   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int OFF_W    = $clog2(BLOCK_BYTES);
   localparam int TAG_W    = 32 - OFF_W - SET_W;
   localparam int RANK_W   = WAY_W;
   localparam int ROWS     = NUM_CORES * NUM_SETS;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int LAT_W    = 10;

   localparam logic [1:0] ST_I = 2'd0;
   localparam logic [1:0] ST_M = 2'd1;
   localparam logic [1:0] ST_E = 2'd2;
   localparam logic [1:0] ST_S = 2'd3;

   localparam logic [1:0] CSR_HIT  = 2'd0;
   localparam logic [1:0] CSR_XFER = 2'd1;
   localparam logic [1:0] CSR_MEM  = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              present;
      logic [1:0]        mesi;
      logic [RANK_W-1:0] rank;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_PEER  = 4'b0100,
      S_OWN   = 4'b1000
   } state_type;
endpackage

// ===== hdl/mesi_snoop_coherence_lru.sv =====
// Coherence controller for four private set-associative tag stores kept in MESI.
// One beat is taken at a time. The sequencer reads the requester's row of the set from a
// single shared tag memory (one row per cycle, registered read). When a load misses, or a
// store misses or hits a shared line, it walks the other cores' rows one per cycle. Then
// it rewrites the requester's row. An item that stays in its own cache passes through accept,
// own lookup and own update; a walk adds a peer step for each other core between lookup and
// update. The result register is loaded with the own update. A result still waiting there
// holds the item in its last step, but does not block the next accept. After reset a
// clearing pass writes all NUM_CORES*NUM_SETS rows (256) of the memory before the first
// request is accepted.
module mesi_snoop_coherence_lru
   import msc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_core,
   input  logic                req_opcode,
   input  logic [31:0]         req_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [9:0]          rsp_latency,
   output logic [1:0]          rsp_new_state,
   output logic                rsp_from_peer,
   output logic [1:0]          rsp_supplier,
   output logic                rsp_supplier_dirty,
   output logic [1:0]          rsp_invalidations,
   output logic                rsp_evicted,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   row_type mem [ROWS];
   row_type rd_ff;

   state_type st_ff, st_in;
   logic              clr_ff;
   logic [ROW_W-1:0]  clr_cnt_ff;
   logic [CORE_W-1:0] core_ff;
   logic              store_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic [CORE_W-1:0] peer_ff;
   logic              found_ff;
   logic [CORE_W-1:0] sup_ff;
   logic              dirty_ff;
   logic [1:0]        inv_ff;
   logic [7:0]        hit_lat_ff, xfer_lat_ff;
   logic [9:0]        mem_lat_ff;

   logic        ov_ff;
   logic        o_hit_ff, o_peer_ff, o_dirty_ff, o_ev_ff;
   logic [9:0]  o_lat_ff;
   logic [1:0]  o_nst_ff, o_sup_ff, o_inv_ff;

   logic              we;
   logic [ROW_W-1:0]  waddr, raddr;
   row_type           wdata;
   logic              req_take, own_fire;

   // lookup on the registered row
   logic              lk_hit;
   logic [WAY_W-1:0]  lk_way;
   logic [1:0]        lk_mesi;
   always_comb begin
      lk_hit = 1'b0;
      lk_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!lk_hit && rd_ff[w].present && rd_ff[w].tag == tag_ff) begin
            lk_hit = 1'b1;
            lk_way = WAY_W'(w);
         end
      end
      lk_mesi = lk_hit ? rd_ff[lk_way].mesi : ST_I;
   end

   function automatic row_type make_recent(row_type r, logic [WAY_W-1:0] way);
      row_type o;
      o = r;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) != way && r[w].present && r[w].rank < r[way].rank) begin
            o[w].rank = r[w].rank + 1'b1;
         end
      end
      o[way].rank = '0;
      return o;
   endfunction

   // requester fill
   row_type           own_row;
   logic              own_ev;
   logic [1:0]        own_st;
   always_comb begin
      logic              free;
      logic [WAY_W-1:0]  fw, vw;
      row_type           r;
      free = 1'b0;
      fw = '0;
      vw = '0;
      r = rd_ff;
      own_ev = 1'b0;
      if (store_ff) own_st = ST_M;
      else if (lk_mesi != ST_I) own_st = lk_mesi;
      else own_st = found_ff ? ST_S : ST_E;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!rd_ff[w].present) begin
            free = 1'b1;
            fw = WAY_W'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (rd_ff[w].rank > rd_ff[vw].rank) vw = WAY_W'(w);
      end
      if (lk_hit) begin
         r[lk_way].mesi = own_st;
         own_row = make_recent(r, lk_way);
      end else if (free) begin
         for (int w = 0; w < WAYS; w++) begin
            if (rd_ff[w].present && rd_ff[w].rank < RANK_W'(WAYS - 1))
               r[w].rank = rd_ff[w].rank + 1'b1;
         end
         r[fw].present = 1'b1;
         r[fw].rank    = '0;
         r[fw].tag     = tag_ff;
         r[fw].mesi    = own_st;
         own_row = make_recent(r, fw);
      end else begin
         r[vw].tag  = tag_ff;
         r[vw].mesi = own_st;
         own_ev = 1'b1;
         own_row = make_recent(r, vw);
      end
   end

   // peer snoop update
   logic    peer_act, peer_holds;
   row_type peer_row;
   always_comb begin
      peer_holds = lk_hit && lk_mesi != ST_I;
      peer_act   = 1'b0;
      peer_row   = rd_ff;
      if (peer_holds) begin
         if (store_ff) begin
            peer_act = 1'b1;
            peer_row[lk_way].mesi = ST_I;
         end else if (!found_ff) begin
            peer_act = 1'b1;
            peer_row[lk_way].mesi = ST_S;
            peer_row = make_recent(peer_row, lk_way);
         end
      end
   end

   // load miss, store miss and store to a shared line must visit the other cores
   logic own_needs_peers;
   assign own_needs_peers = !(lk_mesi != ST_I && (!store_ff || lk_mesi != ST_S));

   // peers in ascending order, skipping the requester
   logic [CORE_W-1:0] first_peer;
   logic [CORE_W:0]   nxt_peer;
   logic              peer_last;
   always_comb begin
      first_peer = (core_ff == '0) ? CORE_W'(1) : '0;
      nxt_peer   = {1'b0, peer_ff} + 1'b1;
      if (nxt_peer == {1'b0, core_ff}) nxt_peer = nxt_peer + 1'b1;
      peer_last  = nxt_peer >= (CORE_W+1)'(NUM_CORES);
   end

   assign req_stall = clr_ff || st_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign own_fire  = st_ff == S_OWN && (!ov_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      st_in = st_ff;
      we    = 1'b0;
      waddr = {core_ff, set_ff};
      wdata = own_row;
      raddr = {core_ff, set_ff};
      case (st_ff)
         S_IDLE: begin
            if (clr_ff) begin
               we    = 1'b1;
               waddr = clr_cnt_ff;
               wdata = '0;
            end else if (req_take) begin
               st_in = S_READ;
               raddr = {req_core, req_address[OFF_W +: SET_W]};
            end
         end
         S_READ: begin
            if (own_needs_peers) begin
               st_in = S_PEER;
               raddr = {first_peer, set_ff};
            end else begin
               st_in = S_OWN;
            end
         end
         S_PEER: begin
            we    = peer_act;
            waddr = {peer_ff, set_ff};
            wdata = peer_row;
            if (peer_last) st_in = S_OWN;
            else raddr = {nxt_peer[CORE_W-1:0], set_ff};
         end
         S_OWN: begin
            if (own_fire) begin
               we    = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         ov_ff        <= 1'b0;
         hit_lat_ff   <= 8'd1;
         xfer_lat_ff  <= 8'd2;
         mem_lat_ff   <= 10'd100;
      end else begin
         st_ff <= st_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HIT:  hit_lat_ff  <= csr_data[7:0];
               CSR_XFER: xfer_lat_ff <= csr_data[7:0];
               CSR_MEM:  mem_lat_ff  <= csr_data[9:0];
               default: ;
            endcase
         end
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ROW_W'(ROWS - 1)) clr_ff <= 1'b0;
         end
         ov_ff <= own_fire || (ov_ff && rsp_stall);
      end
   end

   // request capture, peer walk bookkeeping and result register
   always_ff @(posedge clock) begin
      if (req_take) begin
         core_ff  <= req_core;
         store_ff <= req_opcode;
         tag_ff   <= req_address[31 -: TAG_W];
         set_ff   <= req_address[OFF_W +: SET_W];
         found_ff <= 1'b0;
         inv_ff   <= 2'd0;
         sup_ff   <= '0;
         dirty_ff <= 1'b0;
      end else if (st_ff == S_PEER) begin
         if (peer_holds && !store_ff && !found_ff) begin
            found_ff <= 1'b1;
            sup_ff   <= peer_ff;
            dirty_ff <= lk_mesi == ST_M;
         end
         if (peer_holds && store_ff && inv_ff != 2'd3) inv_ff <= inv_ff + 1'b1;
      end
      if (st_ff == S_READ) peer_ff <= first_peer;
      else if (st_ff == S_PEER) peer_ff <= nxt_peer[CORE_W-1:0];
      if (own_fire) begin
         o_hit_ff   <= lk_mesi != ST_I;
         o_nst_ff   <= own_st;
         o_peer_ff  <= found_ff;
         o_sup_ff   <= found_ff ? sup_ff : '0;
         o_dirty_ff <= found_ff & dirty_ff;
         o_inv_ff   <= inv_ff;
         o_ev_ff    <= own_ev;
         if (lk_mesi != ST_I) o_lat_ff <= {2'b00, hit_lat_ff};
         else if (found_ff)   o_lat_ff <= {2'b00, xfer_lat_ff};
         else                 o_lat_ff <= mem_lat_ff;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_hit            = o_hit_ff;
   assign rsp_latency        = o_lat_ff;
   assign rsp_new_state      = o_nst_ff;
   assign rsp_from_peer      = o_peer_ff;
   assign rsp_supplier       = o_sup_ff;
   assign rsp_supplier_dirty = o_dirty_ff;
   assign rsp_invalidations  = o_inv_ff;
   assign rsp_evicted        = o_ev_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_noacc_clr: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> req_stall) else $error("request taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
endmodule

// ===== bench/tb_mesi_snoop_coherence_lru.sv =====
// self-checking bench for the mesi snoop coherence block with lru tag stores
// depends on msc_pkg and mesi_snoop_coherence_lru; a local predictor tracks every cache
`timescale 1ns / 1ps
module tb_mesi_snoop_coherence_lru;
   import msc_pkg::*;

   typedef struct packed {
      logic       hit;
      logic [9:0] latency;
      logic [1:0] new_state;
      logic       from_peer;
      logic [1:0] supplier;
      logic       supplier_dirty;
      logic [1:0] invalidations;
      logic       evicted;
   } access_result_type;

   typedef struct {
      logic [1:0]  core;
      logic        opcode;
      logic [31:0] address;
      logic        known;
      access_result_type res;
   } access_row_type;

   localparam int LINE_CNT = NUM_CORES * NUM_SETS * WAYS;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_opcode = 0;
   logic req_stall;
   logic [1:0] req_core = 0;
   logic [31:0] req_address = 0;
   logic rsp_valid, rsp_stall = 0;
   logic rsp_hit, rsp_from_peer, rsp_supplier_dirty, rsp_evicted;
   logic [9:0] rsp_latency;
   logic [1:0] rsp_new_state, rsp_supplier, rsp_invalidations;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = CSR_HIT;
   logic [31:0] csr_data = 0;

   mesi_snoop_coherence_lru dut (.*);

   always #4 clock = ~clock;

   // predictor copy of the tag stores and latency registers
   logic [TAG_W-1:0] pt_tag [LINE_CNT];
   logic             pt_present [LINE_CNT];
   logic [1:0]       pt_mesi [LINE_CNT];
   int               pt_rank [LINE_CNT];
   logic [7:0] lat_hit, lat_xfer;
   logic [9:0] lat_mem;

   access_result_type pending_results[$];
   int errors = 0, n_sent = 0, n_rcvd = 0, n_hits = 0, n_peer = 0, n_evict = 0;
   longint cycles = 0;
   logic [TAG_W-1:0] hot_tags [4];

   function automatic int row_base(int c, int s);
      return (c * NUM_SETS + s) * WAYS;
   endfunction

   function automatic int lookup_way(int b, logic [TAG_W-1:0] t);
      for (int w = 0; w < WAYS; w++)
         if (pt_present[b+w] && pt_tag[b+w] == t) return w;
      return -1;
   endfunction

   function automatic void promote(int b, int way);
      int r;
      r = pt_rank[b+way];
      for (int w = 0; w < WAYS; w++)
         if (w != way && pt_present[b+w] && pt_rank[b+w] < r) pt_rank[b+w]++;
      pt_rank[b+way] = 0;
   endfunction

   function automatic logic install_line(int b, logic [TAG_W-1:0] t, logic [1:0] st);
      int way;
      logic ev;
      ev = 0;
      way = lookup_way(b, t);
      if (way < 0) begin
         for (int w = 0; w < WAYS; w++)
            if (!pt_present[b+w] && way < 0) way = w;
         if (way >= 0) begin
            for (int w = 0; w < WAYS; w++)
               if (pt_present[b+w] && pt_rank[b+w] < WAYS - 1) pt_rank[b+w]++;
            pt_present[b+way] = 1;
            pt_rank[b+way] = 0;
         end else begin
            way = 0;
            for (int w = 1; w < WAYS; w++)
               if (pt_rank[b+w] > pt_rank[b+way]) way = w;
            ev = 1;
         end
         pt_tag[b+way] = t;
      end
      pt_mesi[b+way] = st;
      promote(b, way);
      return ev;
   endfunction

   function automatic access_result_type coherence_access(logic [1:0] core, logic op,
                                                          logic [31:0] addr);
      access_result_type r;
      int s, b, way, ob, ow;
      logic [TAG_W-1:0] t;
      logic [1:0] own;
      r = '0;
      s = int'((addr / BLOCK_BYTES) % NUM_SETS);
      t = TAG_W'(addr / (BLOCK_BYTES * NUM_SETS));
      b = row_base(core, s);
      way = lookup_way(b, t);
      own = (way >= 0) ? pt_mesi[b+way] : ST_I;
      r.hit = (own != ST_I);
      if (op == OP_STORE) begin
         r.latency = r.hit ? 10'(lat_hit) : lat_mem;
         if (!r.hit || own == ST_S)
            for (int c = 0; c < NUM_CORES; c++) begin
               if (c == core) continue;
               ob = row_base(c, s);
               ow = lookup_way(ob, t);
               if (ow >= 0 && pt_mesi[ob+ow] != ST_I) begin
                  pt_mesi[ob+ow] = ST_I;
                  if (r.invalidations < 3) r.invalidations++;
               end
            end
         r.evicted = install_line(b, t, ST_M);
         r.new_state = ST_M;
      end else if (r.hit) begin
         r.latency = 10'(lat_hit);
         r.new_state = own;
         promote(b, way);
      end else begin
         for (int c = 0; c < NUM_CORES; c++) begin
            if (c == core || r.from_peer) continue;
            ob = row_base(c, s);
            ow = lookup_way(ob, t);
            if (ow >= 0 && pt_mesi[ob+ow] != ST_I) begin
               r.from_peer = 1;
               r.supplier = 2'(c);
               r.supplier_dirty = (pt_mesi[ob+ow] == ST_M);
               pt_mesi[ob+ow] = ST_S;
               promote(ob, ow);
            end
         end
         r.new_state = r.from_peer ? ST_S : ST_E;
         r.latency = r.from_peer ? 10'(lat_xfer) : lat_mem;
         r.evicted = install_line(b, t, r.new_state);
      end
      return r;
   endfunction

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            access_result_type e;
            e = pending_results.pop_front();
            n_rcvd++;
            if (rsp_hit !== e.hit) begin
               $error("hit exp %0d got %0d", e.hit, rsp_hit); errors++; end
            if (rsp_latency !== e.latency) begin
               $error("latency exp %0d got %0d", e.latency, rsp_latency); errors++; end
            if (rsp_new_state !== e.new_state) begin
               $error("new_state exp %0d got %0d", e.new_state, rsp_new_state); errors++; end
            if (rsp_from_peer !== e.from_peer) begin
               $error("from_peer exp %0d got %0d", e.from_peer, rsp_from_peer); errors++; end
            if (rsp_supplier !== e.supplier) begin
               $error("supplier exp %0d got %0d", e.supplier, rsp_supplier); errors++; end
            if (rsp_supplier_dirty !== e.supplier_dirty) begin
               $error("supplier_dirty exp %0d got %0d", e.supplier_dirty,
                      rsp_supplier_dirty); errors++; end
            if (rsp_invalidations !== e.invalidations) begin
               $error("invalidations exp %0d got %0d", e.invalidations,
                      rsp_invalidations); errors++; end
            if (rsp_evicted !== e.evicted) begin
               $error("evicted exp %0d got %0d", e.evicted, rsp_evicted); errors++; end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver back-pressure: stall for a random count after each beat
   initial begin
      int hold;
      @(posedge clock iff !reset);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (hold != 0) begin
            rsp_stall <= 1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic write_latency(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock iff csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_HIT:  lat_hit  = val[7:0];
         CSR_XFER: lat_xfer = val[7:0];
         default:  lat_mem  = val[9:0];
      endcase
      @(posedge clock);
   endtask

   // valid stays up after an accept so that a zero gap gives a back to back beat
   task automatic send_access(logic [1:0] core, logic op, logic [31:0] addr);
      int gap;
      access_result_type r;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1;
      req_core    <= core;
      req_opcode  <= op;
      req_address <= addr;
      @(posedge clock iff !req_stall);
      r = coherence_access(core, op, addr);
      pending_results = {pending_results, r};
      n_sent++;
      n_hits  += r.hit;
      n_peer  += r.from_peer;
      n_evict += r.evicted;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      a = $urandom;
      if ($urandom_range(0, 9) < 8)
         // reuse a few tags over a handful of sets to build sharing and evictions
         a = {hot_tags[$urandom_range(0, 3)], 6'($urandom_range(0, 3)), 5'($urandom)};
      return a;
   endfunction

   access_row_type directed [] = '{
      '{2'd0, OP_LOAD,  32'h0000_0000, 1, '{0, 10'd100, ST_E, 0, 2'd0, 0, 2'd0, 0}},
      '{2'd0, OP_LOAD,  32'h0000_001F, 1, '{1, 10'd1,   ST_E, 0, 2'd0, 0, 2'd0, 0}},
      '{2'd1, OP_LOAD,  32'h0000_0000, 1, '{0, 10'd2,   ST_S, 1, 2'd0, 0, 2'd0, 0}},
      '{2'd2, OP_STORE, 32'h0000_0004, 1, '{0, 10'd100, ST_M, 0, 2'd0, 0, 2'd2, 0}},
      '{2'd3, OP_LOAD,  32'h0000_0008, 1, '{0, 10'd2,   ST_S, 1, 2'd2, 1, 2'd0, 0}},
      '{2'd3, OP_STORE, 32'h0000_0008, 0, '0},
      '{2'd3, OP_STORE, 32'h0000_0010, 0, '0},
      '{2'd0, OP_LOAD,  32'h0000_0000, 0, '0},
      '{2'd1, OP_STORE, 32'hFFFF_FFFF, 0, '0},
      '{2'd1, OP_LOAD,  32'hFFFF_F7E0, 0, '0},
      '{2'd1, OP_LOAD,  32'hFFFF_FFE0, 0, '0},
      '{2'd1, OP_LOAD,  32'hFFFF_F7E0, 0, '0},
      '{2'd1, OP_STORE, 32'hFFFF_EFE0, 0, '0},
      '{2'd1, OP_LOAD,  32'hFFFF_FFE0, 0, '0},
      '{2'd2, OP_LOAD,  32'h0000_0000, 0, '0},
      '{2'd0, OP_STORE, 32'h0000_0800, 0, '0},
      '{2'd0, OP_STORE, 32'h0000_1000, 0, '0},
      '{2'd1, OP_LOAD,  32'h0000_0000, 0, '0},
      '{2'd2, OP_STORE, 32'hAAAA_5555, 0, '0},
      '{2'd3, OP_LOAD,  32'h5555_AAAA, 0, '0}
   };

   initial begin
      int phase;
      for (int i = 0; i < LINE_CNT; i++) begin
         pt_present[i] = 0; pt_mesi[i] = ST_I; pt_rank[i] = 0; pt_tag[i] = '0;
      end
      lat_hit = 1; lat_xfer = 2; lat_mem = 100;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_access(directed[i].core, directed[i].opcode, directed[i].address);
         if (directed[i].known && pending_results[$] != directed[i].res) begin
            $error("directed row %0d disagrees with predictor", i);
            errors++;
         end
      end
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_latency(CSR_HIT, 32'd255); write_latency(CSR_XFER, 32'd255);
                     write_latency(CSR_MEM, 32'd1023); end
            1: begin write_latency(CSR_HIT, 32'd1); write_latency(CSR_XFER, 32'd1);
                     write_latency(CSR_MEM, 32'd1); end
            2: begin write_latency(CSR_HIT, 32'd0); write_latency(CSR_XFER, 32'd0);
                     write_latency(CSR_MEM, 32'hFFFF_FFFF); end
            default: begin
               write_latency(CSR_HIT, $urandom); write_latency(CSR_XFER, $urandom);
               write_latency(CSR_MEM, $urandom);
            end
         endcase
         foreach (hot_tags[k]) hot_tags[k] = (k == 3) ? TAG_W'($urandom) : TAG_W'(k);
         for (int n = 0; n < 305; n++)
            send_access(2'($urandom), 1'($urandom), pick_address());
         drain();
      end

      $display("%0d accesses sent, %0d responses checked", n_sent, n_rcvd);
      $display("%0d hits, %0d peer transfers, %0d evictions", n_hits, n_peer, n_evict);
      if (errors == 0 && pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
